/* rtl/mis_pkg.sv */
// Shared constants and link types for the merge insertion sorter.
// Used by mis_cell, merge_insertion_sorter and tb_top; depends on nothing else.
package mis_pkg;

    // Capacity of the insertion chain, one value per cell.
    localparam int MAX_COUNT = 64;
    // Width of a held-value count, able to hold MAX_COUNT itself.
    localparam int CNT_W     = $clog2(MAX_COUNT + 1);
    localparam int DATA_W    = 32;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic              insert;
        logic              shift;
        logic [DATA_W-1:0] key;
    } t_cell_ctrl;

    // What a cell hands to its right-hand neighbor.
    typedef struct packed {
        logic              gt;
        logic [DATA_W-1:0] value;
    } t_cell_link;

endpackage

/* rtl/mis_cell.sv */
// One cell of the insertion chain: holds one value, compares it with the broadcast key.
// Depends on mis_pkg for the control and link types.
module mis_cell (
    input  logic                        i_clk,
    input  mis_pkg::t_cell_ctrl         i_ctrl,
    input  logic                        i_occupied,
    input  logic                        i_left_occupied,
    input  mis_pkg::t_cell_link         i_left,
    input  logic [mis_pkg::DATA_W-1:0]  i_right_value,
    output mis_pkg::t_cell_link         o_link
);
    import mis_pkg::*;

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;
    logic              w_gt;
    logic              w_first_empty;

    // This cell holds a value greater than the key, so the key lands at or left of it.
    assign w_gt          = i_occupied && ($signed(r_value) > $signed(i_ctrl.key));
    // The first free cell takes part in the insertion as well.
    assign w_first_empty = !i_occupied && i_left_occupied;

    // Next value: move right on insertion, move left on emission.
    always_comb begin
        n_value = r_value;
        if (i_ctrl.insert) begin
            if (i_left.gt) begin
                n_value = i_left.value;
            end else if (w_gt || w_first_empty) begin
                n_value = i_ctrl.key;
            end
        end else if (i_ctrl.shift) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.gt    = w_gt;
    assign o_link.value = r_value;

endmodule

/* rtl/merge_insertion_sorter.sv */
// Top level of the merge insertion sorter: occupancy count, emission control, chain of cells.
// Depends on mis_pkg and mis_cell.
//
// Usage: values arrive on the s_axis channel, one item each, with tlast on the final
// value of a set. Each accepted value is inserted into a chain of MAX_COUNT cells as
// it is taken, so a set loads at one item per cycle. After the item with tlast is taken,
// the set leaves on the m_axis channel in ascending order, smallest first, one item per
// cycle while the receiver takes them: the first result is valid in the cycle after the
// tlast item is taken. tlast marks the greatest value, and tuser carries the overflow
// flag on every result of a set in which values beyond the capacity were dropped. While
// a set drains, s_axis tready is low; it rises again in the cycle after the last result
// is taken. A stall on m_axis simply holds the chain, and cell 0 acts as the output
// register. Reset empties the chain, clears the overflow flag and returns the block to
// loading; the stored values need no clearing since only occupied cells are ever read.
module merge_insertion_sorter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [mis_pkg::DATA_W-1:0]  i_s_axis_tdata,   // [31:0] value
    input  logic                        i_s_axis_tlast,   // end_of_set
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [mis_pkg::DATA_W-1:0]  o_m_axis_tdata,   // [31:0] sorted_value
    output logic                        o_m_axis_tlast,   // final_result
    output logic                        o_m_axis_tuser    // [0] overflow
);
    import mis_pkg::*;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_emit;
    logic              n_emit;
    logic              r_dropped;
    logic              n_dropped;

    logic              w_in_accept;
    logic              w_out_accept;
    logic              w_full;
    t_cell_ctrl        w_ctrl;
    logic [MAX_COUNT-1:0] w_occ;
    t_cell_link        w_link [MAX_COUNT];

    assign w_full       = (r_count == CNT_W'(MAX_COUNT));
    assign w_in_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_accept = o_m_axis_tvalid && i_m_axis_tready;

    // Broadcast control: insert while loading with room, shift left on each result taken.
    assign w_ctrl.insert = w_in_accept && !w_full;
    assign w_ctrl.shift  = w_out_accept;
    assign w_ctrl.key    = i_s_axis_tdata;

    // Count, emission mode and overflow flag.
    always_comb begin
        n_count   = r_count;
        n_emit    = r_emit;
        n_dropped = r_dropped;
        if (w_in_accept) begin
            if (w_full) begin
                n_dropped = 1'b1;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
            if (i_s_axis_tlast) begin
                n_emit = 1'b1;
            end
        end
        if (w_out_accept) begin
            n_count = r_count - CNT_W'(1);
            if (r_count == CNT_W'(1)) begin
                n_emit    = 1'b0;
                n_dropped = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_emit    <= 1'b0;
            r_dropped <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_emit    <= n_emit;
            r_dropped <= n_dropped;
        end
    end

    // The chain of cells; cells below the count are occupied.
    for (genvar gi = 0; gi < MAX_COUNT; gi++) begin : g_cell
        t_cell_link        w_left;
        logic              w_left_occ;
        logic [DATA_W-1:0] w_right_value;

        assign w_occ[gi] = (CNT_W'(gi) < r_count);

        if (gi == 0) begin : g_first
            assign w_left.gt    = 1'b0;
            assign w_left.value = '0;
            assign w_left_occ   = 1'b1;
        end else begin : g_inner
            assign w_left     = w_link[gi-1];
            assign w_left_occ = w_occ[gi-1];
        end

        if (gi == MAX_COUNT - 1) begin : g_last
            assign w_right_value = '0;
        end else begin : g_body
            assign w_right_value = w_link[gi+1].value;
        end

        mis_cell u_cell (
            .i_clk           (i_clk),
            .i_ctrl          (w_ctrl),
            .i_occupied      (w_occ[gi]),
            .i_left_occupied (w_left_occ),
            .i_left          (w_left),
            .i_right_value   (w_right_value),
            .o_link          (w_link[gi])
        );
    end

    // Handshake and result fields; cell 0 holds the smallest remaining value.
    assign o_s_axis_tready = !r_emit;
    assign o_m_axis_tvalid = r_emit && (r_count != '0);
    assign o_m_axis_tdata  = w_link[0].value;
    assign o_m_axis_tlast  = (r_count == CNT_W'(1));
    assign o_m_axis_tuser  = r_dropped;

endmodule

/* tb/tb_top.sv */
// Self-checking bench for merge_insertion_sorter: streams sets of signed values in,
// predicts the ascending output and checks every emitted item against it.
// Depends on mis_pkg and the merge_insertion_sorter RTL.
module tb_top;

    import mis_pkg::*;

    // One predicted output item.
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              fin;
        logic              ovf;
    } t_sorted_item;

    // Keeps the sorted contents of the open set and the queue of items still to come out.
    class sort_scoreboard;
        logic signed [DATA_W-1:0] held_values[$];
        bit                       lost_values;
        t_sorted_item             pending_items[$];
        int                       mismatches;
        int                       checked_items;
        int                       sets_closed;
        int                       overflow_sets;

        // Inserts one accepted value and, when it closes the set, queues the sorted set.
        function void note_value(logic [DATA_W-1:0] v, logic set_end);
            int           pos;
            int           k;
            t_sorted_item it;
            if (held_values.size() >= MAX_COUNT) begin
                lost_values = 1'b1;
            end else begin
                pos = held_values.size();
                while (pos > 0 && held_values[pos-1] > $signed(v)) begin
                    pos--;
                end
                held_values.insert(pos, v);
            end
            if (set_end) begin
                for (k = 0; k < held_values.size(); k++) begin
                    it.value = held_values[k];
                    it.fin   = (k == held_values.size() - 1);
                    it.ovf   = lost_values;
                    pending_items.insert(pending_items.size(), it);
                end
                sets_closed++;
                if (lost_values) begin
                    overflow_sets++;
                end
                held_values.delete();
                lost_values = 1'b0;
            end
        endfunction

        // Compares one emitted item with the oldest prediction.
        function void check_output(logic [DATA_W-1:0] v, logic fin, logic ovf);
            t_sorted_item want;
            if (pending_items.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("tb: unexpected item value=%0d last=%0b user=%0b",
                             $signed(v), fin, ovf);
                end
            end else begin
                want = pending_items.pop_front();
                checked_items++;
                if (want.value !== v || want.fin !== fin || want.ovf !== ovf) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"tb: mismatch expected value=%0d last=%0b user=%0b,",
                                  " got value=%0d last=%0b user=%0b"},
                                 $signed(want.value), want.fin, want.ovf,
                                 $signed(v), fin, ovf);
                    end
                end
            end
        endfunction

        function int outstanding();
            return pending_items.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [DATA_W-1:0] i_s_axis_tdata = '0;   // [31:0] value
    logic              i_s_axis_tlast = 1'b0; // end_of_set
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [DATA_W-1:0] o_m_axis_tdata;        // [31:0] sorted_value
    logic              o_m_axis_tlast;        // final_result
    logic              o_m_axis_tuser;        // [0] overflow

    sort_scoreboard    sorted_sb = new();
    logic              idle_on = 1'b1;
    int                sink_stall = 0;
    int                values_sent = 0;
    logic [DATA_W-1:0] prev_value = '0;

    merge_insertion_sorter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Clock with a period of 10 time units.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output side: check each taken item, then pick tready for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sorted_sb.check_output(o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser);
        end
        if (!idle_on) begin
            i_m_axis_tready <= 1'b1;
        end else if (sink_stall > 0) begin
            sink_stall      <= sink_stall - 1;
            i_m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 6) == 0) begin
            sink_stall      <= $urandom_range(0, 8);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Presents one value, with an optional idle burst first, and waits until it is taken.
    task automatic send_value(input logic [DATA_W-1:0] v, input logic set_end);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= v;
        i_s_axis_tlast  <= set_end;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        sorted_sb.note_value(v, set_end);
        values_sent++;
    endtask

    // Holds the input idle until every predicted item has come out.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (sorted_sb.outstanding() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Mix of full-range values, a narrow band for duplicates, extremes and repeats.
    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom;
            5, 6:          v = $urandom_range(0, 16) - 8;
            7:             v = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            8:             v = $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 3)
                                                    : 32'h8000_0000 + $urandom_range(0, 3);
            default:       v = prev_value;
        endcase
        prev_value = v;
        return v;
    endfunction

    // Sends a whole set of random values, the last one marked.
    task automatic send_random_set(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            send_value(pick_value(), k == count - 1);
        end
    endtask

    // Stimulus: directed sets, then random sets, then drain.
    initial begin
        int set_idx;
        int set_len;
        int random_target;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A single extreme value, then the extremes mixed with zero and its neighbors.
        send_value(32'h8000_0000, 1'b1);
        send_value(32'h7fff_ffff, 1'b0);
        send_value(32'h8000_0000, 1'b0);
        send_value(32'h0000_0000, 1'b0);
        send_value(32'hffff_ffff, 1'b0);
        send_value(32'h0000_0001, 1'b0);
        send_value(32'h5555_aaaa, 1'b1);
        // Duplicates, including equal maxima.
        send_value(32'd5, 1'b0);
        send_value(32'd5, 1'b0);
        send_value(-32'sd5, 1'b0);
        send_value(32'd5, 1'b1);
        send_value(32'h7fff_ffff, 1'b0);
        send_value(32'h7fff_ffff, 1'b1);
        // Descending arrival, and a closing value that lands in the middle.
        send_value(32'd3, 1'b0);
        send_value(32'd2, 1'b0);
        send_value(32'd1, 1'b1);
        send_value(-32'sd100, 1'b0);
        send_value(32'd100, 1'b0);
        send_value(32'd0, 1'b1);
        wait_drained();

        // Random sets; a few are forced to fill or overflow the store.
        random_target = values_sent + 330;
        set_idx = 0;
        while (values_sent < random_target) begin
            if (values_sent >= random_target - 40) begin
                idle_on <= 1'b0;
            end else begin
                idle_on <= ($urandom_range(0, 3) != 0);
            end
            case (set_idx)
                2:       set_len = MAX_COUNT;
                5:       set_len = MAX_COUNT + 1;
                9:       set_len = MAX_COUNT + 6;
                default: set_len = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 70)
                                                                : $urandom_range(1, 12);
            endcase
            send_random_set(set_len);
            if (set_idx % 7 == 3) begin
                wait_drained();
            end
            set_idx++;
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("tb: %0d values in %0d sets, %0d sorted items checked, %0d sets with overflow",
                 values_sent, sorted_sb.sets_closed, sorted_sb.checked_items,
                 sorted_sb.overflow_sets);
        if (sorted_sb.mismatches == 0 && sorted_sb.outstanding() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
